[rtl/imc_pkg.sv]
// ----------------------------------------------------------------------------
// imc_pkg
// shared types and constants of the ipv6 neighbor cache update block
// ----------------------------------------------------------------------------
package imc_pkg;

  localparam int unsigned IPV6_ADDR_W = 128;
  localparam int unsigned IPV6_ADDR_BYTES = 16;
  localparam int unsigned IPV6_HALF_W = IPV6_ADDR_W / 2;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned ACTION_W = 2;

  localparam int unsigned DEF_TABLE_ENTRIES = 8;

  // stream payload widths, rounded up to whole bytes
  localparam int unsigned IN_BITS = IPV6_ADDR_BYTES * 8 + MAC_W + STAMP_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = SLOT_W + ACTION_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UPDATED  = 2'd0,
    ACT_INSERTED = 2'd1,
    ACT_REPLACED = 2'd2
  } action_e;

  // one cache entry, also the latched input item
  typedef struct packed {
    logic [STAMP_W-1:0]     stamp;
    logic [MAC_W-1:0]       mac;
    logic [IPV6_HALF_W-1:0] key_lo;
    logic [IPV6_HALF_W-1:0] key_hi;
  } entry_t;

endpackage

[rtl/imc_mem.sv]
// ----------------------------------------------------------------------------
// imc_mem
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module imc_mem #(
  parameter int unsigned TABLE_ENTRIES = imc_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output imc_pkg::entry_t     rd_data_o,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  imc_pkg::entry_t     wr_data_i
);

  imc_pkg::entry_t mem_q [TABLE_ENTRIES];
  imc_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/imc_ctrl.sv]
// ----------------------------------------------------------------------------
// imc_ctrl
// scan sequencer: match search, oldest-entry tracking, write back, result reg
// ----------------------------------------------------------------------------
module imc_ctrl #(
  parameter int unsigned TABLE_ENTRIES = imc_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  imc_pkg::entry_t                in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [imc_pkg::SLOT_W-1:0]     out_slot_o,
  output imc_pkg::action_e               out_action_o,
  output logic                           rd_en_o,
  output logic [IDX_W-1:0]               rd_addr_o,
  input  imc_pkg::entry_t                rd_data_i,
  output logic                           wr_en_o,
  output logic [IDX_W-1:0]               wr_addr_o,
  output imc_pkg::entry_t                wr_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e                            state_q;
  logic [CNT_W-1:0]                  count_q;
  logic [CNT_W-1:0]                  rd_idx_q;
  logic                              pend_q;
  logic [IDX_W-1:0]                  data_idx_q;
  logic [imc_pkg::STAMP_W-1:0]       min_stamp_q;
  logic [IDX_W-1:0]                  min_idx_q;
  imc_pkg::entry_t                   item_q;
  logic [IDX_W-1:0]                  slot_q;
  imc_pkg::action_e                  act_q;
  logic                              out_valid_q;
  logic [imc_pkg::SLOT_W-1:0]        out_slot_q;
  imc_pkg::action_e                  out_act_q;

  logic                              match;
  logic                              older;
  logic                              last;
  logic                              full;
  logic                              fire;
  logic [IDX_W+imc_pkg::SLOT_W-1:0]  slot_ext;

  assign match = pend_q && (rd_data_i.key_hi == item_q.key_hi)
                        && (rd_data_i.key_lo == item_q.key_lo);
  // first entry seeds the minimum, strict compare keeps the lowest index on ties
  assign older = (data_idx_q == '0) || (rd_data_i.stamp < min_stamp_q);
  assign last  = (CNT_W'(data_idx_q) + CNT_W'(1)) == count_q;
  assign full  = count_q == CNT_W'(TABLE_ENTRIES);
  assign fire  = !out_valid_q || out_ready_i;

  assign rd_en_o   = (state_q == ST_SCAN) && (rd_idx_q < count_q);
  assign rd_addr_o = rd_idx_q[IDX_W-1:0];
  assign wr_en_o   = (state_q == ST_WRITE) && fire;
  assign wr_addr_o = slot_q;
  assign wr_data_o = item_q;

  assign slot_ext = {{imc_pkg::SLOT_W{1'b0}}, slot_q};

  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign out_slot_o   = out_slot_q;
  assign out_action_o = out_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces a drained one in the same cycle
      if ((state_q == ST_WRITE) && fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q   <= in_item_i;
            rd_idx_q <= '0;
            pend_q   <= 1'b0;
            if (count_q == '0) begin
              slot_q  <= '0;
              act_q   <= imc_pkg::ACT_INSERTED;
              count_q <= CNT_W'(1);
              state_q <= ST_WRITE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_q <= rd_en_o;
          if (rd_en_o) begin
            rd_idx_q   <= rd_idx_q + CNT_W'(1);
            data_idx_q <= rd_addr_o;
          end
          if (pend_q) begin
            if (match) begin
              slot_q  <= data_idx_q;
              act_q   <= imc_pkg::ACT_UPDATED;
              state_q <= ST_WRITE;
            end else begin
              if (older) begin
                min_stamp_q <= rd_data_i.stamp;
                min_idx_q   <= data_idx_q;
              end
              if (last) begin
                if (full) begin
                  slot_q <= older ? data_idx_q : min_idx_q;
                  act_q  <= imc_pkg::ACT_REPLACED;
                end else begin
                  slot_q  <= count_q[IDX_W-1:0];
                  act_q   <= imc_pkg::ACT_INSERTED;
                  count_q <= count_q + CNT_W'(1);
                end
                state_q <= ST_WRITE;
              end
            end
          end
        end
        ST_WRITE: begin
          if (fire) begin
            out_slot_q  <= slot_ext[imc_pkg::SLOT_W-1:0];
            out_act_q   <= act_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/ipv6_mac_cache_update_top.sv]
// ----------------------------------------------------------------------------
// ipv6_mac_cache_update_top
// ipv6 to mac neighbor cache: update on hit, insert while room, else evict oldest
// ----------------------------------------------------------------------------
// an input item is resolved by a sequential scan of the valid entries, ended early
//   by a hit and skipped for an empty table; write back waits on a stalled result
// a new item is taken only once the previous one is written back, a limit set by
//   the sequential scan over the single read port of the entry memory
// a new item is taken while the previous result still waits on the output register
// reset: asynchronous, active low; clears the fill count and handshake state,
//   entry memory contents stay undefined until written
module ipv6_mac_cache_update_top #(
  parameter int unsigned TABLE_ENTRIES = imc_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input item stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] ipv6_high, [127:64] ipv6_low, [175:128] mac_addr, [207:176] now_secs
  input  logic [imc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] slot_index, [4:3] action, [7:5] zero
  output logic [imc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  imc_pkg::entry_t                in_item;
  logic [imc_pkg::SLOT_W-1:0]     out_slot;
  imc_pkg::action_e               out_action;

  // memory port wiring
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  imc_pkg::entry_t                rd_data;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  imc_pkg::entry_t                wr_data;

  // unpack the input transfer, fields from the lowest bit up
  assign in_item.key_hi = s_axis_tdata[63:0];
  assign in_item.key_lo = s_axis_tdata[127:64];
  assign in_item.mac    = s_axis_tdata[175:128];
  assign in_item.stamp  = s_axis_tdata[207:176];

  // pack the result, upper bits zero
  assign m_axis_tdata = {{(imc_pkg::OUT_DATA_W - imc_pkg::OUT_BITS){1'b0}},
                         out_action, out_slot};

  // sequencer: scans entries 0 .. count-1 one per cycle up to the first hit, then writes back once
  imc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_slot_o   (out_slot),
    .out_action_o (out_action),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  // entry store: key halves, mac and timestamp in one wide word
  imc_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

[rtl/imc_checker.sv]
// ----------------------------------------------------------------------------
// imc_checker
// port-level checks of the neighbor cache update block
// ----------------------------------------------------------------------------
module imc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [imc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [imc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: input closes right after a transfer
  a_in_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after transfer");

  // a new result comes with the sequencer back at rest
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while item still in work");

  // padding bits and unused action code
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[imc_pkg::OUT_DATA_W-1:imc_pkg::OUT_BITS] == '0)
                      && (m_axis_tdata[4:3] != 2'd3))
    else $error("bad result encoding");

endmodule

bind ipv6_mac_cache_update_top imc_checker u_imc_checker (.*);

[verif/tb_ipv6_mac_cache_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv6_mac_cache_update_top
// self-checking bench for the ipv6 neighbor cache update block: a cycle-free
// model of the cache predicts the slot and action of every accepted update,
// the result stream is checked in order, with random bursts on the input side
// and a shifting stall pattern on the output side
// ----------------------------------------------------------------------------
module tb_ipv6_mac_cache_update_top;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned DRAIN_EVERY = 250;
  localparam int unsigned TAIL_CYCLES = 2 * (TABLE_ENTRIES + 3);
  localparam int unsigned LIMIT_CYCLES = 500_000;

  // slot and action that one update is expected to report
  typedef struct {
    logic [imc_pkg::SLOT_W-1:0] slot;
    imc_pkg::action_e           action;
  } slot_report_t;

  // tracks the cache contents and the reports still owed by the block
  class cache_tracker;
    imc_pkg::entry_t cache_tab [TABLE_ENTRIES];
    int unsigned     fill;
    slot_report_t    owed_reports[$];
    int unsigned     errors;

    // apply one accepted update to the cache and queue the report it causes
    function void note_update(imc_pkg::entry_t it);
      slot_report_t rep;
      int unsigned  victim;
      bit           hit;
      hit = 1'b0;
      victim = 0;
      rep.slot = '0;
      rep.action = imc_pkg::ACT_UPDATED;
      for (int unsigned i = 0; i < fill; i++) begin
        if (!hit && cache_tab[i].key_hi == it.key_hi && cache_tab[i].key_lo == it.key_lo) begin
          hit = 1'b1;
          cache_tab[i].mac = it.mac;
          cache_tab[i].stamp = it.stamp;
          rep.slot = imc_pkg::SLOT_W'(i);
          rep.action = imc_pkg::ACT_UPDATED;
        end
      end
      if (!hit) begin
        if (fill < TABLE_ENTRIES) begin
          victim = fill;
          fill++;
          rep.action = imc_pkg::ACT_INSERTED;
        end else begin
          // oldest stamp goes, strict compare keeps the lowest index on a tie
          for (int unsigned i = 1; i < TABLE_ENTRIES; i++) begin
            if (cache_tab[victim].stamp > cache_tab[i].stamp) victim = i;
          end
          rep.action = imc_pkg::ACT_REPLACED;
        end
        cache_tab[victim] = it;
        rep.slot = imc_pkg::SLOT_W'(victim);
      end
      owed_reports.push_back(rep);
    endfunction

    function void check_result(logic [imc_pkg::OUT_DATA_W-1:0] data);
      slot_report_t want;
      if (owed_reports.size() == 0) begin
        $display("%0t: result slot %0d action %0d arrived with no update pending",
                 $time, data[2:0], data[4:3]);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      if (data[2:0] !== want.slot) begin
        $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                 $time, want.slot, data[2:0]);
        errors++;
      end
      if (data[4:3] !== want.action) begin
        $display("%0t: action mismatch, expected %0d, actual %0d",
                 $time, want.action, data[4:3]);
        errors++;
      end
      if (data[imc_pkg::OUT_DATA_W-1:5] !== '0) begin
        $display("%0t: padding mismatch, expected 0, actual %0h",
                 $time, data[imc_pkg::OUT_DATA_W-1:5]);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_reports.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [imc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [imc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  cache_tracker cache_sb;
  int unsigned  cycle_cnt = 0;

  // receiver stall pattern state
  int unsigned  stall_mode = 0;
  int unsigned  stall_left = 0;

  // address pool for the random part, wider than the table so entries churn
  logic [imc_pkg::IPV6_HALF_W-1:0] pool_hi [POOL_SIZE];
  logic [imc_pkg::IPV6_HALF_W-1:0] pool_lo [POOL_SIZE];
  logic [imc_pkg::STAMP_W-1:0]     wall_secs;

  ipv6_mac_cache_update_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, reckoned from the slowest legal run several times over
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check every transfer, then pick the next tready value
  // modes: always ready, coin flip, mostly stalled, periodic stall
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      cache_sb.check_result(m_axis_tdata);
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= (cycle_cnt % 5) != 0;
      end
    endcase
  end

  // present one update and hold it until the block takes it
  task automatic send_update(input imc_pkg::entry_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    cache_sb.note_update(it);
  endtask

  task automatic send_fields(input logic [imc_pkg::IPV6_HALF_W-1:0] hi,
                             input logic [imc_pkg::IPV6_HALF_W-1:0] lo,
                             input logic [imc_pkg::MAC_W-1:0]       mac,
                             input logic [imc_pkg::STAMP_W-1:0]     stamp);
    imc_pkg::entry_t it;
    it.key_hi = hi;
    it.key_lo = lo;
    it.mac = mac;
    it.stamp = stamp;
    send_update(it);
  endtask

  // idle gap on the input side; zero keeps tvalid high for back-to-back transfers
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // stop sending until every owed report has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (cache_sb.outstanding() != 0);
  endtask

  // mostly known addresses so hits and evictions dominate, plus near misses
  // that match only one half and fresh addresses that churn the pool
  function automatic imc_pkg::entry_t next_update();
    imc_pkg::entry_t it;
    int unsigned     pick;
    int unsigned     roll;
    int unsigned     bit_idx;
    pick = $urandom_range(0, POOL_SIZE - 1);
    roll = $urandom_range(0, 99);
    bit_idx = $urandom_range(0, imc_pkg::IPV6_HALF_W - 1);
    if (roll < 14) begin
      pool_hi[pick] = {$urandom, $urandom};
      pool_lo[pick] = {$urandom, $urandom};
    end else if (roll < 16) begin
      pool_hi[pick] = (roll == 14) ? '1 : '0;
      pool_lo[pick] = {$urandom, $urandom};
    end
    it.key_hi = pool_hi[pick];
    it.key_lo = pool_lo[pick];
    if (roll >= 90 && roll < 95) begin
      it.key_hi[bit_idx] = ~it.key_hi[bit_idx];
    end else if (roll >= 95) begin
      it.key_lo[bit_idx] = ~it.key_lo[bit_idx];
    end
    it.mac = {16'($urandom), 32'($urandom)};
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      // advancing time with frequent equal stamps
      wall_secs = wall_secs + imc_pkg::STAMP_W'($urandom_range(0, 2));
      it.stamp = wall_secs;
    end else if (roll < 65) begin
      it.stamp = imc_pkg::STAMP_W'($urandom_range(0, 15));
    end else if (roll < 85) begin
      it.stamp = $urandom;
    end else if (roll < 90) begin
      it.stamp = '0;
    end else if (roll < 95) begin
      it.stamp = '1;
    end else begin
      it.stamp = wall_secs - imc_pkg::STAMP_W'($urandom_range(0, 50));
    end
    return it;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    cache_sb = new();
    wall_secs = imc_pkg::STAMP_W'($urandom_range(0, 1000));
    for (int unsigned i = 0; i < POOL_SIZE; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill the table from empty with the field extremes
    send_fields('0, '0, '0, '0);
    send_fields('1, '1, '1, '1);
    // hit on slot 0 with a new mac and stamp
    send_fields('0, '0, 48'h1, 32'd5);
    // addresses that share only one half with a stored one are misses
    send_fields('1, '0, 48'h0000_0000_00aa, 32'd3);
    send_fields('0, '1, 48'h0000_0000_00bb, 32'd9);
    // equal oldest stamps on slots 2 and 4
    send_fields(64'hfe80_0000_0000_0000, 64'h0000_0000_0000_0004, 48'h0200_0000_0004, 32'd3);
    send_fields(64'hfe80_0000_0000_0000, 64'h0000_0000_0000_0005, 48'h0200_0000_0005, 32'd100);
    send_fields(64'hfe80_0000_0000_0000, 64'h0000_0000_0000_0006, 48'h0200_0000_0006, 32'd200);
    send_fields(64'hfe80_0000_0000_0000, 64'h0000_0000_0000_0007, 48'h0200_0000_0007, 32'd300);
    // table full: hit moves slot 1 from the newest to a middle stamp
    send_fields('1, '1, 48'h0200_0000_0011, 32'd50);
    // misses on a full table evict the oldest, lowest index on a tie
    send_fields(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0008, 48'h0200_0000_0008, 32'd400);
    send_fields(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0009, 48'h0200_0000_0009, 32'd500);
    send_fields(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_000a, 48'h0200_0000_000a, 32'd0);
    // hit on a replaced entry, then the evicted address returns as a miss
    send_fields(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_000a, 48'h0200_0000_001a, '1);
    send_fields('0, '0, 48'h0200_0000_0000, 32'd7);
    send_fields(64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff, 48'h8000_0000_0001, '1);
    // let the block run dry before the random part
    wait_idle();

    // random: bursts of random length with random gaps, drained now and then
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int unsigned b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_update(next_update());
        sent++;
        if (sent % DRAIN_EVERY == 0) wait_idle();
      end
      if ($urandom_range(0, 3) == 0) begin
        hold_off(0);
      end else begin
        hold_off($urandom_range(1, 12));
      end
    end

    // wait out the remaining reports, then TAIL_CYCLES more for any stray result
    s_axis_tvalid <= 1'b0;
    while (cache_sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (cache_sb.errors == 0 && cache_sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[ipv6_mac_cache_update_top.f]
rtl/imc_pkg.sv
rtl/imc_mem.sv
rtl/imc_ctrl.sv
rtl/ipv6_mac_cache_update_top.sv
rtl/imc_checker.sv
verif/tb_ipv6_mac_cache_update_top.sv
